// ===== rtl/sae_pkg.sv =====
// Shared types and constants for the swept box entry time block.
// No dependencies; the files that use it refer to this package by scoped names.
package sae_pkg;

  // Displacement format: signed Q16.8.
  localparam int MOVE_BITS      = 24;
  localparam int MOVE_FRAC_BITS = 8;

  // Side codes reported with a result.
  typedef enum logic [2:0] {
    SIDE_NONE   = 3'd0,
    SIDE_TOP    = 3'd1,
    SIDE_BOTTOM = 3'd2,
    SIDE_LEFT   = 3'd3,
    SIDE_RIGHT  = 3'd4
  } side_t;

  // Per-axis classification made in the front end.
  typedef struct packed {
    logic zero;         // no move on this axis
    logic ent_gap_neg;  // entry gap is negative
    logic ent_neg;      // entry time is negative
    logic ext_neg;      // exit time is negative
  } axis_flags_t;

endpackage

// ===== rtl/sae_front.sv =====
// Front end: orders the box edges by move sign, forms the gaps and their magnitudes.
// Depends on sae_pkg.
module sae_front #(
  parameter int COORD_BITS = 16
) (
  input  logic signed [COORD_BITS-1:0]         moving_left,
  input  logic signed [COORD_BITS-1:0]         moving_top,
  input  logic signed [COORD_BITS-1:0]         moving_right,
  input  logic signed [COORD_BITS-1:0]         moving_bottom,
  input  logic signed [COORD_BITS-1:0]         target_left,
  input  logic signed [COORD_BITS-1:0]         target_top,
  input  logic signed [COORD_BITS-1:0]         target_right,
  input  logic signed [COORD_BITS-1:0]         target_bottom,
  input  logic signed [sae_pkg::MOVE_BITS-1:0] move_x,
  input  logic signed [sae_pkg::MOVE_BITS-1:0] move_y,
  output logic [COORD_BITS:0]                  gxe_mag,
  output logic [COORD_BITS:0]                  gxx_mag,
  output logic [COORD_BITS:0]                  gye_mag,
  output logic [COORD_BITS:0]                  gyx_mag,
  output logic [sae_pkg::MOVE_BITS-1:0]        vx_mag,
  output logic [sae_pkg::MOVE_BITS-1:0]        vy_mag,
  output sae_pkg::axis_flags_t                 fx,
  output sae_pkg::axis_flags_t                 fy
);

  localparam int GW = COORD_BITS + 1;

  logic signed [GW-1:0] gxe, gxx, gye, gyx;
  logic                 vx_neg, vy_neg, vx_pos, vy_pos;

  assign vx_neg = move_x[sae_pkg::MOVE_BITS-1];
  assign vy_neg = move_y[sae_pkg::MOVE_BITS-1];
  assign vx_pos = !vx_neg && (move_x != '0);
  assign vy_pos = !vy_neg && (move_y != '0);

  // Entry and exit gaps follow the direction of the move.
  always_comb begin
    if (vx_pos) begin
      gxe = GW'(target_left) - GW'(moving_right);
      gxx = GW'(target_right) - GW'(moving_left);
    end else begin
      gxe = GW'(target_right) - GW'(moving_left);
      gxx = GW'(target_left) - GW'(moving_right);
    end
    if (vy_pos) begin
      gye = GW'(target_top) - GW'(moving_bottom);
      gyx = GW'(target_bottom) - GW'(moving_top);
    end else begin
      gye = GW'(target_bottom) - GW'(moving_top);
      gyx = GW'(target_top) - GW'(moving_bottom);
    end
  end

  // Magnitudes feed the unsigned dividers; signs travel as flags.
  assign gxe_mag = gxe[GW-1] ? GW'(-gxe) : GW'(gxe);
  assign gxx_mag = gxx[GW-1] ? GW'(-gxx) : GW'(gxx);
  assign gye_mag = gye[GW-1] ? GW'(-gye) : GW'(gye);
  assign gyx_mag = gyx[GW-1] ? GW'(-gyx) : GW'(gyx);
  assign vx_mag  = vx_neg ? sae_pkg::MOVE_BITS'(-move_x) : sae_pkg::MOVE_BITS'(move_x);
  assign vy_mag  = vy_neg ? sae_pkg::MOVE_BITS'(-move_y) : sae_pkg::MOVE_BITS'(move_y);

  assign fx.zero        = (move_x == '0);
  assign fx.ent_gap_neg = gxe[GW-1];
  assign fx.ent_neg     = gxe[GW-1] ^ vx_neg;
  assign fx.ext_neg     = gxx[GW-1] ^ vx_neg;
  assign fy.zero        = (move_y == '0);
  assign fy.ent_gap_neg = gye[GW-1];
  assign fy.ent_neg     = gye[GW-1] ^ vy_neg;
  assign fy.ext_neg     = gyx[GW-1] ^ vy_neg;

endmodule

// ===== rtl/sae_fifo.sv =====
// Two-entry request queue between the front end and the divider back end.
// No package dependencies.
module sae_fifo #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic         not_empty,
  output logic [W-1:0] rdata
);

  logic [W-1:0] mem_r [0:1];
  logic         wptr_r, rptr_r;
  logic [1:0]   count_r;

  assign full      = (count_r == 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign rdata     = mem_r[rptr_r];

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= wdata;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= 1'b0;
      rptr_r  <= 1'b0;
      count_r <= 2'd0;
    end else begin
      if (push) wptr_r <= !wptr_r;
      if (pop)  rptr_r <= !rptr_r;
      if (push && !pop)      count_r <= count_r + 2'd1;
      else if (pop && !push) count_r <= count_r - 2'd1;
    end
  end

endmodule

// ===== rtl/sae_div.sv =====
// Pipelined restoring divider: floor(num * 2^FRAC / den), saturated at 2.0.
// One quotient bit per stage, after an entry stage. No package dependencies.
module sae_div #(
  parameter int NUM_W = 25,
  parameter int DEN_W = 24,
  parameter int FRAC  = 16
) (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [FRAC+1:0]  mag
);

  localparam int R_W   = DEN_W + 1;
  localparam int EXT_W = (NUM_W > R_W) ? NUM_W : R_W;
  localparam int Q_W   = FRAC + 1;
  localparam int STEPS = FRAC + 1;

  logic [R_W-1:0]   r_r   [0:STEPS];
  logic [Q_W-1:0]   q_r   [0:STEPS];
  logic [DEN_W-1:0] d_r   [0:STEPS];
  logic             sat_r [0:STEPS];

  logic [EXT_W-1:0] num_ext, den2_ext;
  logic             sat_in;

  assign num_ext  = EXT_W'(num);
  assign den2_ext = EXT_W'({den, 1'b0});
  assign sat_in   = (num_ext >= den2_ext);

  // Entry stage: a quotient of 2.0 or more saturates at once.
  always_ff @(posedge clk) begin
    if (en) begin
      sat_r[0] <= sat_in;
      r_r[0]   <= sat_in ? '0 : num_ext[R_W-1:0];
      q_r[0]   <= '0;
      d_r[0]   <= den;
    end
  end

  // One compare and subtract per stage.
  for (genvar k = 0; k < STEPS; k++) begin : g_step
    logic           ge;
    logic [R_W-1:0] diff;
    assign ge   = (r_r[k] >= {1'b0, d_r[k]});
    assign diff = ge ? (r_r[k] - {1'b0, d_r[k]}) : r_r[k];
    always_ff @(posedge clk) begin
      if (en) begin
        r_r[k+1]   <= {diff[R_W-2:0], 1'b0};
        q_r[k+1]   <= {q_r[k][Q_W-2:0], ge};
        d_r[k+1]   <= d_r[k];
        sat_r[k+1] <= sat_r[k];
      end
    end
  end

  assign mag = sat_r[STEPS] ? {1'b1, Q_W'(0)} : {1'b0, q_r[STEPS]};

endmodule

// ===== rtl/sae_back.sv =====
// Back end: four dividers, a matching flag delay line, the min/max selection
// and the output register. Depends on sae_pkg and sae_div.
module sae_back #(
  parameter int COORD_BITS     = 16,
  parameter int TIME_FRAC_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            src_valid,
  output logic                            src_pop,
  input  logic [COORD_BITS:0]             gxe_mag,
  input  logic [COORD_BITS:0]             gxx_mag,
  input  logic [COORD_BITS:0]             gye_mag,
  input  logic [COORD_BITS:0]             gyx_mag,
  input  logic [sae_pkg::MOVE_BITS-1:0]   vx_mag,
  input  logic [sae_pkg::MOVE_BITS-1:0]   vy_mag,
  input  sae_pkg::axis_flags_t            fx,
  input  sae_pkg::axis_flags_t            fy,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [TIME_FRAC_BITS:0]         out_entry_time,
  output logic [2:0]                      out_hit_side
);

  localparam int NUM_W = COORD_BITS + 1 + sae_pkg::MOVE_FRAC_BITS;
  localparam int LAT   = TIME_FRAC_BITS + 2;
  localparam int M_W   = TIME_FRAC_BITS + 2;
  localparam int TW    = TIME_FRAC_BITS + 4;
  localparam logic signed [TW-1:0] T_ONE = signed'(TW'(1) << TIME_FRAC_BITS);
  localparam logic signed [TW-1:0] T_INF = signed'(TW'(4) << TIME_FRAC_BITS);

  logic                 en;
  logic [M_W-1:0]       mxe, mxx, mye, myx;
  logic                 vld_r [0:LAT-1];
  sae_pkg::axis_flags_t fx_r  [0:LAT-1];
  sae_pkg::axis_flags_t fy_r  [0:LAT-1];

  logic                 out_valid_r;
  logic [TIME_FRAC_BITS:0] time_r;
  sae_pkg::side_t       side_r;

  // The whole back end moves unless a finished result is held up.
  assign en      = !out_valid_r || !out_stall;
  assign src_pop = en && src_valid;

  // Gap scaled to Q.8 over the move, one divider per time.
  sae_div #(.NUM_W(NUM_W), .DEN_W(sae_pkg::MOVE_BITS), .FRAC(TIME_FRAC_BITS)) u_dxe (
    .clk(clk), .en(en), .num({gxe_mag, sae_pkg::MOVE_FRAC_BITS'(0)}), .den(vx_mag), .mag(mxe));
  sae_div #(.NUM_W(NUM_W), .DEN_W(sae_pkg::MOVE_BITS), .FRAC(TIME_FRAC_BITS)) u_dxx (
    .clk(clk), .en(en), .num({gxx_mag, sae_pkg::MOVE_FRAC_BITS'(0)}), .den(vx_mag), .mag(mxx));
  sae_div #(.NUM_W(NUM_W), .DEN_W(sae_pkg::MOVE_BITS), .FRAC(TIME_FRAC_BITS)) u_dye (
    .clk(clk), .en(en), .num({gye_mag, sae_pkg::MOVE_FRAC_BITS'(0)}), .den(vy_mag), .mag(mye));
  sae_div #(.NUM_W(NUM_W), .DEN_W(sae_pkg::MOVE_BITS), .FRAC(TIME_FRAC_BITS)) u_dyx (
    .clk(clk), .en(en), .num({gyx_mag, sae_pkg::MOVE_FRAC_BITS'(0)}), .den(vy_mag), .mag(myx));

  // Valid bits follow the divider stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < LAT; k++) vld_r[k] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= src_valid;
      for (int k = 1; k < LAT; k++) vld_r[k] <= vld_r[k-1];
    end
  end

  // Flags ride alongside.
  always_ff @(posedge clk) begin
    if (en) begin
      fx_r[0] <= fx;
      fy_r[0] <= fy;
      for (int k = 1; k < LAT; k++) begin
        fx_r[k] <= fx_r[k-1];
        fy_r[k] <= fy_r[k-1];
      end
    end
  end

  // Signed times, with infinity on a motionless axis.
  logic signed [TW-1:0] txe, txx, tye, tyx, ent, ext;
  logic                 reject;
  sae_pkg::axis_flags_t fxl, fyl;
  sae_pkg::side_t       side_c;

  assign fxl = fx_r[LAT-1];
  assign fyl = fy_r[LAT-1];

  always_comb begin
    if (fxl.zero) begin
      txe = -T_INF;
      txx = T_INF;
    end else begin
      txe = fxl.ent_neg ? -signed'(TW'(mxe)) : signed'(TW'(mxe));
      txx = fxl.ext_neg ? -signed'(TW'(mxx)) : signed'(TW'(mxx));
    end
    if (fyl.zero) begin
      tye = -T_INF;
      tyx = T_INF;
    end else begin
      tye = fyl.ent_neg ? -signed'(TW'(mye)) : signed'(TW'(mye));
      tyx = fyl.ext_neg ? -signed'(TW'(myx)) : signed'(TW'(myx));
    end
    ent    = (txe > tye) ? txe : tye;
    ext    = (txx < tyx) ? txx : tyx;
    reject = (ent > ext) || (txe[TW-1] && tye[TW-1]) || (txe > T_ONE) || (tye > T_ONE);
    if (reject) begin
      side_c = sae_pkg::SIDE_NONE;
    end else if (txe < tye) begin
      side_c = fyl.ent_gap_neg ? sae_pkg::SIDE_TOP : sae_pkg::SIDE_BOTTOM;
    end else begin
      side_c = fxl.ent_gap_neg ? sae_pkg::SIDE_LEFT : sae_pkg::SIDE_RIGHT;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vld_r[LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      time_r <= reject ? T_ONE[TIME_FRAC_BITS:0] : ent[TIME_FRAC_BITS:0];
      side_r <= side_c;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_entry_time = time_r;
  assign out_hit_side   = side_r;

endmodule

// ===== rtl/swept_aabb_entry_time_unit.sv =====
// Swept box entry time unit: top level.
// Depends on sae_pkg, sae_front, sae_fifo and sae_back.
//
// Usage: one request carries a moving box, a still box (integer pixel edges)
// and a Q16.8 displacement. The result gives the entry time in Q.16 and the
// struck side, or no hit with time 1.0. Both channels use valid/stall; a
// request is taken at a rising edge with valid high and stall low.
//
// Throughput: one request per cycle while no result is held by out_stall. The
// four gap/move divisions run in restoring divider pipelines with one quotient
// bit per stage. The request passes TIME_FRAC_BITS+4 registers: the two-entry
// request queue (written at the accepting edge), TIME_FRAC_BITS+2 divider
// stages and the output register, which drives out_valid.
//
// Reset (rst_n low, synchronous) empties the queue and drops every request in
// flight. While out_stall holds a result, the back end freezes in place and
// the queue fills; in_stall rises once both queue entries are taken.
module swept_aabb_entry_time_unit #(
  parameter int COORD_BITS     = 16,
  parameter int TIME_FRAC_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic signed [COORD_BITS-1:0]    in_moving_left,
  input  logic signed [COORD_BITS-1:0]    in_moving_top,
  input  logic signed [COORD_BITS-1:0]    in_moving_right,
  input  logic signed [COORD_BITS-1:0]    in_moving_bottom,
  input  logic signed [COORD_BITS-1:0]    in_target_left,
  input  logic signed [COORD_BITS-1:0]    in_target_top,
  input  logic signed [COORD_BITS-1:0]    in_target_right,
  input  logic signed [COORD_BITS-1:0]    in_target_bottom,
  input  logic signed [sae_pkg::MOVE_BITS-1:0] in_move_x,
  input  logic signed [sae_pkg::MOVE_BITS-1:0] in_move_y,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [TIME_FRAC_BITS:0]         out_entry_time,
  output logic [2:0]                      out_hit_side
);

  localparam int GW = COORD_BITS + 1;
  localparam int MB = sae_pkg::MOVE_BITS;
  localparam int FB = $bits(sae_pkg::axis_flags_t);
  localparam int W  = 4 * GW + 2 * MB + 2 * FB;

  logic [GW-1:0]        f_gxe, f_gxx, f_gye, f_gyx, b_gxe, b_gxx, b_gye, b_gyx;
  logic [MB-1:0]        f_vx, f_vy, b_vx, b_vy;
  sae_pkg::axis_flags_t f_fx, f_fy, b_fx, b_fy;
  logic [W-1:0]         q_rdata;
  logic                 q_full, q_not_empty, q_pop, push;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  // Classify the request.
  sae_front #(.COORD_BITS(COORD_BITS)) u_front (
    .moving_left(in_moving_left), .moving_top(in_moving_top),
    .moving_right(in_moving_right), .moving_bottom(in_moving_bottom),
    .target_left(in_target_left), .target_top(in_target_top),
    .target_right(in_target_right), .target_bottom(in_target_bottom),
    .move_x(in_move_x), .move_y(in_move_y),
    .gxe_mag(f_gxe), .gxx_mag(f_gxx), .gye_mag(f_gye), .gyx_mag(f_gyx),
    .vx_mag(f_vx), .vy_mag(f_vy), .fx(f_fx), .fy(f_fy)
  );

  // Queue between front and back.
  sae_fifo #(.W(W)) u_fifo (
    .clk(clk), .rst_n(rst_n), .push(push),
    .wdata({f_gxe, f_gxx, f_gye, f_gyx, f_vx, f_vy, f_fx, f_fy}),
    .full(q_full), .pop(q_pop), .not_empty(q_not_empty), .rdata(q_rdata)
  );

  assign {b_gxe, b_gxx, b_gye, b_gyx, b_vx, b_vy, b_fx, b_fy} = q_rdata;

  // Divide and select.
  sae_back #(.COORD_BITS(COORD_BITS), .TIME_FRAC_BITS(TIME_FRAC_BITS)) u_back (
    .clk(clk), .rst_n(rst_n), .src_valid(q_not_empty), .src_pop(q_pop),
    .gxe_mag(b_gxe), .gxx_mag(b_gxx), .gye_mag(b_gye), .gyx_mag(b_gyx),
    .vx_mag(b_vx), .vy_mag(b_vy), .fx(b_fx), .fy(b_fy),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_entry_time(out_entry_time), .out_hit_side(out_hit_side)
  );

endmodule

// ===== rtl/sae_checker.sv =====
// Port-level checks for the swept box entry time unit, bound to its top level.
// Depends on sae_pkg and swept_aabb_entry_time_unit.
module sae_checker #(
  parameter int TIME_FRAC_BITS = 16
) (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic [TIME_FRAC_BITS:0] out_entry_time,
  input logic [2:0]              out_hit_side
);

  localparam logic [TIME_FRAC_BITS:0] ONE = (TIME_FRAC_BITS + 1)'(1) << TIME_FRAC_BITS;

  // Reset drops every result in flight.
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // A held result stays offered.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid)
    else $error("result dropped while stalled");

  // A miss always reports time 1.0.
  a_miss_time: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_hit_side == sae_pkg::SIDE_NONE) |-> out_entry_time == ONE)
    else $error("miss without time 1.0");

  // A hit lies within the move and names a real side.
  a_hit_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_hit_side != sae_pkg::SIDE_NONE)
      |-> (out_entry_time <= ONE && out_hit_side <= sae_pkg::SIDE_RIGHT))
    else $error("hit out of range");

endmodule

bind swept_aabb_entry_time_unit sae_checker #(.TIME_FRAC_BITS(TIME_FRAC_BITS)) u_sae_checker (
  .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_stall(out_stall),
  .out_entry_time(out_entry_time), .out_hit_side(out_hit_side)
);

// ===== test/tb_swept_aabb_entry_time_unit.sv =====
// Testbench for the swept box entry time unit: directed and random box pairs
// checked against an in-bench predictor through a small scoreboard class.
// Depends on sae_pkg and the swept_aabb_entry_time_unit RTL.
`timescale 1ns / 100ps

module tb_swept_aabb_entry_time_unit;

  localparam int CB = 16;
  localparam int TF = 16;
  localparam int MVB = sae_pkg::MOVE_BITS;
  localparam longint T_ONE = 64'sd1 << TF;
  localparam longint T_SAT = T_ONE * 2;
  localparam longint T_INF = T_ONE * 4;

  typedef struct {
    logic signed [CB-1:0] ml, mt, mr, mb, tl, tt, tr, tb;
    logic signed [MVB-1:0] vx, vy;
  } box_req_t;

  typedef struct {
    logic [TF:0] entry;
    sae_pkg::side_t side;
  } hit_t;

  // Gap over move, truncated toward zero and saturated at +-2.0.
  function automatic longint gap_time(longint gap, longint mv);
    longint num, den, ip, m;
    num = (gap < 0 ? -gap : gap) << sae_pkg::MOVE_FRAC_BITS;
    den = mv < 0 ? -mv : mv;
    ip = num / den;
    if (ip >= 2) m = T_SAT;
    else m = (ip << TF) + ((num % den) << TF) / den;
    return ((gap < 0) != (mv < 0)) ? -m : m;
  endfunction

  // Entry time and struck side for one request.
  function automatic hit_t predict_hit(box_req_t r);
    longint gxe, gxx, gye, gyx, txe, txx, tye, tyx, ent, ext;
    hit_t h;
    if (r.vx > 0) begin gxe = r.tl - r.mr; gxx = r.tr - r.ml; end
    else begin gxe = r.tr - r.ml; gxx = r.tl - r.mr; end
    if (r.vy > 0) begin gye = r.tt - r.mb; gyx = r.tb - r.mt; end
    else begin gye = r.tb - r.mt; gyx = r.tt - r.mb; end
    if (r.vx == 0) begin txe = -T_INF; txx = T_INF; end
    else begin txe = gap_time(gxe, r.vx); txx = gap_time(gxx, r.vx); end
    if (r.vy == 0) begin tye = -T_INF; tyx = T_INF; end
    else begin tye = gap_time(gye, r.vy); tyx = gap_time(gyx, r.vy); end
    ent = txe > tye ? txe : tye;
    ext = txx < tyx ? txx : tyx;
    if (ent > ext || (txe < 0 && tye < 0) || txe > T_ONE || tye > T_ONE) begin
      h.entry = T_ONE[TF:0];
      h.side = sae_pkg::SIDE_NONE;
    end else begin
      h.entry = ent[TF:0];
      if (txe < tye) h.side = gye < 0 ? sae_pkg::SIDE_TOP : sae_pkg::SIDE_BOTTOM;
      else h.side = gxe < 0 ? sae_pkg::SIDE_LEFT : sae_pkg::SIDE_RIGHT;
    end
    return h;
  endfunction

  // Holds expected hits in request order and compares results against them.
  class hit_scoreboard;
    hit_t pending[$];
    int errors = 0;
    int checked = 0;
    int hits = 0;

    function void note_request(box_req_t r);
      pending.push_back(predict_hit(r));
    endfunction

    function void check_result(logic [TF:0] entry, logic [2:0] side);
      hit_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result time=%0d side=%0d", $time, entry, side);
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      if (e.side != sae_pkg::SIDE_NONE) hits++;
      if (entry !== e.entry) begin
        $display("%0t: entry_time expected %0d actual %0d", $time, e.entry, entry);
        errors++;
      end
      if (side !== e.side) begin
        $display("%0t: hit_side expected %0d actual %0d", $time, e.side, side);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [CB-1:0] in_ml = '0, in_mt = '0, in_mr = '0, in_mb = '0;
  logic signed [CB-1:0] in_tl = '0, in_tt = '0, in_tr = '0, in_tb = '0;
  logic signed [MVB-1:0] in_vx = '0, in_vy = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [TF:0] out_entry_time;
  logic [2:0] out_hit_side;

  hit_scoreboard board = new();
  int sent = 0;
  bit stall_on = 1'b1;

  always #6 clk = ~clk;

  swept_aabb_entry_time_unit #(.COORD_BITS(CB), .TIME_FRAC_BITS(TF)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_moving_left(in_ml), .in_moving_top(in_mt),
    .in_moving_right(in_mr), .in_moving_bottom(in_mb),
    .in_target_left(in_tl), .in_target_top(in_tt),
    .in_target_right(in_tr), .in_target_bottom(in_tb),
    .in_move_x(in_vx), .in_move_y(in_vy),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_entry_time(out_entry_time), .out_hit_side(out_hit_side)
  );

  // Results are taken at the rising edge when not stalled.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) board.check_result(out_entry_time, out_hit_side);
  end

  // Receiver stall pattern: alternating calm and busy stretches.
  always @(negedge clk) begin
    if (($urandom_range(0, 63)) == 0) stall_on <= ~stall_on;
    out_stall <= stall_on ? ($urandom_range(0, 3) == 0) : 1'b0;
  end

  // Drive one request and hold it until accepted.
  task automatic send_request(box_req_t r);
    in_ml <= r.ml; in_mt <= r.mt; in_mr <= r.mr; in_mb <= r.mb;
    in_tl <= r.tl; in_tt <= r.tt; in_tr <= r.tr; in_tb <= r.tb;
    in_vx <= r.vx; in_vy <= r.vy;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    board.note_request(r);
    sent++;
    @(negedge clk);
  endtask

  task automatic idle_gap(int n);
    in_valid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  function automatic logic signed [CB-1:0] rnd_coord();
    return $urandom_range(0, 3) == 0 ? CB'($urandom) : CB'($signed($urandom_range(0, 400)) - 200);
  endfunction

  // Random pair, mostly boxes near each other with moves that can reach.
  function automatic box_req_t rnd_request();
    box_req_t r;
    int kind;
    kind = $urandom_range(0, 9);
    if (kind < 7) begin
      r.ml = CB'($signed($urandom_range(0, 200)) - 100);
      r.mt = CB'($signed($urandom_range(0, 200)) - 100);
      r.mr = r.ml + CB'($urandom_range(0, 40));
      r.mb = r.mt + CB'($urandom_range(0, 40));
      r.tl = CB'($signed($urandom_range(0, 200)) - 100);
      r.tt = CB'($signed($urandom_range(0, 200)) - 100);
      r.tr = r.tl + CB'($urandom_range(0, 40));
      r.tb = r.tt + CB'($urandom_range(0, 40));
      r.vx = $urandom_range(0, 7) == 0 ? '0 :
             MVB'($signed($urandom_range(0, 120000)) - 60000);
      r.vy = $urandom_range(0, 7) == 0 ? '0 :
             MVB'($signed($urandom_range(0, 120000)) - 60000);
    end else begin
      r.ml = rnd_coord(); r.mt = rnd_coord(); r.mr = rnd_coord(); r.mb = rnd_coord();
      r.tl = rnd_coord(); r.tt = rnd_coord(); r.tr = rnd_coord(); r.tb = rnd_coord();
      r.vx = MVB'($urandom);
      r.vy = MVB'($urandom);
    end
    return r;
  endfunction

  function automatic box_req_t mk(int ml, int mt, int mr, int mb, int tl, int tt,
                                  int tr, int tb, int vx, int vy);
    box_req_t r;
    r.ml = CB'(ml); r.mt = CB'(mt); r.mr = CB'(mr); r.mb = CB'(mb);
    r.tl = CB'(tl); r.tt = CB'(tt); r.tr = CB'(tr); r.tb = CB'(tb);
    r.vx = MVB'(vx); r.vy = MVB'(vy);
    return r;
  endfunction

  initial begin
    box_req_t dir[$];
    int left;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: hits from each side, still axes, rejections and field extremes.
    dir.push_back(mk(0, 0, 10, 10, 20, 0, 30, 10, 20 * 256, 0));         // right
    dir.push_back(mk(20, 0, 30, 10, 0, 0, 10, 10, -20 * 256, 0));        // left
    dir.push_back(mk(0, 0, 10, 10, 0, 20, 10, 30, 0, 20 * 256));         // bottom
    dir.push_back(mk(0, 20, 10, 30, 0, 0, 10, 10, 0, -20 * 256));        // top
    dir.push_back(mk(0, 0, 10, 10, 50, 50, 60, 60, 0, 0));               // no move
    dir.push_back(mk(0, 0, 10, 10, 500, 0, 510, 10, 256, 0));            // too far
    dir.push_back(mk(0, 0, 10, 10, 20, 500, 30, 510, 20 * 256, 0));      // no overlap check
    dir.push_back(mk(0, 0, 10, 10, 10, 10, 20, 20, 256, 256));           // corner, time 0
    dir.push_back(mk(0, 0, 10, 10, 15, 12, 25, 22, 3 * 256, 7 * 256));   // diagonal
    dir.push_back(mk(0, 0, 10, 10, 13, 0, 23, 10, 3 * 256 + 1, 0));      // exact-ish
    dir.push_back(mk(10, 10, 0, 0, 20, 0, 30, 10, 256, 0));              // inverted box
    dir.push_back(mk(-32768, -32768, 32767, 32767, -32768, -32768, 32767, 32767,
                     -8388608, 8388607));
    dir.push_back(mk(32767, 32767, -32768, -32768, -32768, 32767, 32767, -32768,
                     8388607, -8388608));
    dir.push_back(mk(-32768, 0, -32768, 0, 32767, 0, 32767, 0, 1, -1));
    dir.push_back(mk(0, -32768, 0, 32767, 0, 32767, 0, -32768, -1, 1));
    dir.push_back(mk(0, 0, 10, 10, 5, 5, 15, 15, 256, 256));             // already inside
    dir.push_back(mk(0, 0, 10, 10, 20, 0, 30, 10, 10 * 256, 0));         // exactly 1.0
    dir.push_back(mk(-1, -1, -1, -1, -1, -1, -1, -1, -1, -1));
    foreach (dir[i]) send_request(dir[i]);

    // Random bursts with gaps.
    left = 500;
    while (left > 0) begin
      for (int n = $urandom_range(1, 20); n > 0 && left > 0; n--) begin
        send_request(rnd_request());
        left--;
      end
      if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 8));
    end
    in_valid <= 1'b0;

    while (board.pending.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    $display("Sent %0d box pairs; checked %0d results, %0d of them hits.",
             sent, board.checked, board.hits);
    if (board.errors == 0) $display("swept_aabb_entry_time_unit test passed");
    else $display("swept_aabb_entry_time_unit test failed");
    $finish;
  end

  // Watchdog.
  initial begin
    #2000000;
    $display("swept_aabb_entry_time_unit test failed");
    $finish;
  end

endmodule
